FILE: rtl/core/ign3_pkg.sv
// ----------------------------------------------------------------------------
// ign3_pkg
// Shared constants, types and the edge-gradient function for the 3d gradient
// noise pipeline.
// ----------------------------------------------------------------------------
package ign3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PT_W       = 32;
  localparam int OFF_W      = 24;
  localparam int SUM_W      = PT_W + 1;
  localparam int OUT_W      = 18;
  localparam int GW         = FRAC_BITS + 3;   // gradient and blend values
  localparam int DW         = GW + 1;          // blend difference
  localparam int FW         = FRAC_BITS + 1;   // fade weight, 0..one
  localparam int PW         = DW + FW + 1;     // blend product
  localparam int CFG_IDX_W  = 2;
  localparam int LAT        = 12;              // accept edge to result edge

  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FW-1:0] fade_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } load_t;

  // one of twelve cube-edge gradients, picked by the low hash bits
  function automatic logic signed [GW-1:0] edge_grad(input logic [3:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
      input logic signed [GW-1:0] z);
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) v = y;
    else if (h[3:2] == 2'b11 && !h[0]) v = x;
    else v = z;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage

FILE: rtl/core/ign3_perm_ram.sv
// ----------------------------------------------------------------------------
// ign3_perm_ram
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module ign3_perm_ram (
  input  logic                 clk,
  input  ign3_pkg::load_t      wr,
  input  ign3_pkg::idx_t       raddr_a,
  input  ign3_pkg::idx_t       raddr_b,
  output ign3_pkg::idx_t       rdata_a,
  output ign3_pkg::idx_t       rdata_b
);
  import ign3_pkg::*;

  idx_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/core/ign3_hash.sv
// ----------------------------------------------------------------------------
// ign3_hash
// Three chained table lookups over replicated table copies; a load beat
// travels along and writes each copy at the stage that reads it.
// ----------------------------------------------------------------------------
module ign3_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  ign3_pkg::load_t              ld1,
  input  ign3_pkg::idx_t               cell_x,
  input  ign3_pkg::idx_t               cell_y,
  input  ign3_pkg::idx_t               cell_z,
  output logic [7:0][ign3_pkg::IDX_W-1:0] hash
);
  import ign3_pkg::*;

  load_t ld2;
  load_t ld3;
  idx_t  cy2;
  idx_t  cz2;
  idx_t  cz3;
  idx_t  p0;
  idx_t  p1;
  idx_t  a;
  idx_t  b;
  idx_t  d [4];
  idx_t  base [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      ld2.en <= 1'b0;
      ld3.en <= 1'b0;
    end else begin
      ld2.en <= ld1.en;
      ld3.en <= ld2.en;
    end
    ld2.addr <= ld1.addr;
    ld2.data <= ld1.data;
    ld3.addr <= ld2.addr;
    ld3.data <= ld2.data;
    cy2 <= cell_y;
    cz2 <= cell_z;
    cz3 <= cz2;
  end

  ign3_perm_ram u_ram1 (
    .clk(clk), .wr(ld1), .raddr_a(cell_x), .raddr_b(cell_x + idx_t'(1)),
    .rdata_a(p0), .rdata_b(p1)
  );

  assign a = p0 + cy2;
  assign b = p1 + cy2;

  ign3_perm_ram u_ram2a (
    .clk(clk), .wr(ld2), .raddr_a(a), .raddr_b(a + idx_t'(1)),
    .rdata_a(d[0]), .rdata_b(d[1])
  );

  ign3_perm_ram u_ram2b (
    .clk(clk), .wr(ld2), .raddr_a(b), .raddr_b(b + idx_t'(1)),
    .rdata_a(d[2]), .rdata_b(d[3])
  );

  // corners aa, ab, ba, bb; each copy also serves the +1 neighbor
  for (genvar i = 0; i < 4; i++) begin : g_ram3
    assign base[i] = d[i] + cz3;
    ign3_perm_ram u_ram3 (
      .clk(clk), .wr(ld3), .raddr_a(base[i]), .raddr_b(base[i] + idx_t'(1)),
      .rdata_a(hash[2*i]), .rdata_b(hash[2*i+1])
    );
  end

endmodule

FILE: rtl/core/ign3_fade.sv
// ----------------------------------------------------------------------------
// ign3_fade
// Quintic fade weight over three register stages, one multiply level each.
// ----------------------------------------------------------------------------
module ign3_fade (
  input  logic              clk,
  input  ign3_pkg::frac_t   t,
  output ign3_pkg::fade_t   fade
);
  import ign3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int QW = F + 4;
  localparam logic [QW-1:0] ONE15 = QW'(15 * (1 << F));
  localparam logic [QW-1:0] ONE10 = QW'(10 * (1 << F));

  logic [QW-1:0]    u;
  logic [2*F+3:0]   tu;
  logic [2*F-1:0]   tt;
  logic [2*F-1:0]   t2t;
  logic [2*F+3:0]   t3q;
  frac_t            t_d;
  frac_t            t2;
  frac_t            t3;
  logic [QW-1:0]    w;
  logic [QW-1:0]    q;

  assign u   = ONE15 - ({4'b0, t} * QW'(6));
  assign tu  = {4'b0, t} * {{F{1'b0}}, u};
  assign tt  = t * t;
  assign t2t = t2 * t_d;
  assign t3q = {4'b0, t3} * {{F{1'b0}}, q};

  always_ff @(posedge clk) begin
    t2   <= tt[2*F-1:F];
    w    <= tu[2*F+3:F];
    t_d  <= t;
    t3   <= t2t[2*F-1:F];
    q    <= ONE10 - w;
    fade <= t3q[2*F:F];
  end

endmodule

FILE: rtl/core/ign3_blend.sv
// ----------------------------------------------------------------------------
// ign3_blend
// Corner gradients, then the x, y and z blends as multiply and add stages,
// then scaling and saturation into the result register.
// ----------------------------------------------------------------------------
module ign3_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ev4,
  input  logic [7:0][ign3_pkg::IDX_W-1:0] hash,
  input  ign3_pkg::frac_t                 fr_x,
  input  ign3_pkg::frac_t                 fr_y,
  input  ign3_pkg::frac_t                 fr_z,
  input  ign3_pkg::fade_t                 fd_x,
  input  ign3_pkg::fade_t                 fd_y,
  input  ign3_pkg::fade_t                 fd_z,
  output logic signed [ign3_pkg::OUT_W-1:0] noise_value,
  output logic                            noise_valid
);
  import ign3_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int WW   = 40;
  localparam int SH_R = (F >= 16) ? F - 16 : 0;
  localparam int SH_L = (F < 16) ? 16 - F : 0;
  localparam logic signed [WW-1:0] OUT_MAX = WW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [WW-1:0] OUT_MIN = -WW'(1 << (OUT_W - 1));
  localparam logic signed [GW-1:0] ONE = GW'(1 << F);

  logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [GW-1:0] g [8];
  logic [6:0]           ev;
  fade_t                fx5;
  fade_t                fy [3];
  fade_t                fz [5];
  logic signed [GW-1:0] a6 [4];
  logic signed [PW-1:0] p6 [4];
  logic signed [GW-1:0] l7 [4];
  logic signed [GW-1:0] a8 [2];
  logic signed [PW-1:0] p8 [2];
  logic signed [GW-1:0] m9 [2];
  logic signed [GW-1:0] a10;
  logic signed [PW-1:0] p10;
  logic signed [GW-1:0] v11;
  logic signed [WW-1:0] vw;
  logic signed [WW-1:0] vs;

  function automatic logic signed [PW-1:0] blend_mul(input logic signed [GW-1:0] ga,
      input logic signed [GW-1:0] gb, input fade_t w);
    logic signed [DW-1:0] df;
    df = DW'(gb) - DW'(ga);
    return PW'(df) * PW'($signed({1'b0, w}));
  endfunction

  assign x0 = $signed({3'b0, fr_x});
  assign y0 = $signed({3'b0, fr_y});
  assign z0 = $signed({3'b0, fr_z});
  assign x1 = x0 - ONE;
  assign y1 = y0 - ONE;
  assign z1 = z0 - ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev          <= '0;
      noise_valid <= 1'b0;
    end else begin
      ev          <= {ev[5:0], ev4};
      noise_valid <= ev[5];
    end
  end

  // hash order: aa, aa+1, ab, ab+1, ba, ba+1, bb, bb+1
  always_ff @(posedge clk) begin
    g[0] <= edge_grad(hash[0][3:0], x0, y0, z0);
    g[1] <= edge_grad(hash[1][3:0], x0, y0, z1);
    g[2] <= edge_grad(hash[2][3:0], x0, y1, z0);
    g[3] <= edge_grad(hash[3][3:0], x0, y1, z1);
    g[4] <= edge_grad(hash[4][3:0], x1, y0, z0);
    g[5] <= edge_grad(hash[5][3:0], x1, y0, z1);
    g[6] <= edge_grad(hash[6][3:0], x1, y1, z0);
    g[7] <= edge_grad(hash[7][3:0], x1, y1, z1);
    fx5  <= fd_x;
    fy[0] <= fd_y;
    fy[1] <= fy[0];
    fy[2] <= fy[1];
    fz[0] <= fd_z;
    for (int i = 1; i < 5; i++) fz[i] <= fz[i-1];
    // x blends: l1 (aa,ba) l2 (ab,bb) l3 (aa+1,ba+1) l4 (ab+1,bb+1)
    a6[0] <= g[0]; p6[0] <= blend_mul(g[0], g[4], fx5);
    a6[1] <= g[2]; p6[1] <= blend_mul(g[2], g[6], fx5);
    a6[2] <= g[1]; p6[2] <= blend_mul(g[1], g[5], fx5);
    a6[3] <= g[3]; p6[3] <= blend_mul(g[3], g[7], fx5);
    for (int i = 0; i < 4; i++) l7[i] <= a6[i] + GW'(p6[i] >>> F);
    a8[0] <= l7[0]; p8[0] <= blend_mul(l7[0], l7[1], fy[2]);
    a8[1] <= l7[2]; p8[1] <= blend_mul(l7[2], l7[3], fy[2]);
    for (int i = 0; i < 2; i++) m9[i] <= a8[i] + GW'(p8[i] >>> F);
    a10 <= m9[0];
    p10 <= blend_mul(m9[0], m9[1], fz[4]);
    noise_value <= OUT_W'(vs > OUT_MAX ? OUT_MAX : (vs < OUT_MIN ? OUT_MIN : vs));
  end

  assign v11 = a10 + GW'(p10 >>> F);
  assign vw  = WW'(v11);
  assign vs  = (vw <<< SH_L) >>> SH_R;

endmodule

FILE: rtl/core/improved_gradient_noise_3d_top.sv
// ----------------------------------------------------------------------------
// improved_gradient_noise_3d_top
// 3d improved gradient noise: offset add and cell split, chained table
// lookups, fade weights, seven blends, saturated Q1.16 result.
//
//   channel   signals                                     direction
//   command   start, busy, command, point_*, table_*      in
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
//   result    noise_valid, noise_value                    out
//
// one command beat per cycle; busy stays low, the pipeline never stalls
// an evaluation passes the offset add, the table lookups and the blends in order;
// its result is on the ports while noise_valid is high
// a load beat writes each table copy as it passes that copy's lookup stage
// reset clears valid bits and offsets; the table is not cleared
// ----------------------------------------------------------------------------
module improved_gradient_noise_3d_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic signed [ign3_pkg::PT_W-1:0]       point_x,
  input  logic signed [ign3_pkg::PT_W-1:0]       point_y,
  input  logic signed [ign3_pkg::PT_W-1:0]       point_z,
  input  logic [ign3_pkg::IDX_W-1:0]             table_index,
  input  logic [ign3_pkg::IDX_W-1:0]             table_value,
  output logic signed [ign3_pkg::OUT_W-1:0]      noise_value,
  output logic                                   noise_valid,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ign3_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ign3_pkg::OFF_W-1:0]             cfg_data
);
  import ign3_pkg::*;

  logic [OFF_W-1:0]     x_offset;
  logic [OFF_W-1:0]     y_offset;
  logic [OFF_W-1:0]     z_offset;
  logic                 v0;
  logic                 cmd0;
  logic signed [PT_W-1:0] px0, py0, pz0;
  idx_t                 tidx0;
  idx_t                 tval0;
  logic [SUM_W-1:0]     sx, sy, sz;
  logic [3:0]           ev;
  load_t                ld1;
  idx_t                 cx1, cy1, cz1;
  frac_t                fr [3][4];
  fade_t                fd_x, fd_y, fd_z;
  logic [7:0][IDX_W-1:0] hash;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
      z_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_OFFSET: x_offset <= cfg_data;
        REG_Y_OFFSET: y_offset <= cfg_data;
        REG_Z_OFFSET: z_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      ld1.en <= 1'b0;
      ev     <= '0;
    end else begin
      v0     <= start && !busy;
      ld1.en <= v0 && (cmd0 == CMD_LOAD);
      ev     <= {ev[2:0], v0 && (cmd0 == CMD_EVAL)};
    end
    cmd0     <= command;
    px0      <= point_x;
    py0      <= point_y;
    pz0      <= point_z;
    tidx0    <= table_index;
    tval0    <= table_value;
    ld1.addr <= tidx0;
    ld1.data <= tval0;
    cx1      <= sx[FRAC_BITS +: IDX_W];
    cy1      <= sy[FRAC_BITS +: IDX_W];
    cz1      <= sz[FRAC_BITS +: IDX_W];
    fr[0][0] <= sx[FRAC_BITS-1:0];
    fr[1][0] <= sy[FRAC_BITS-1:0];
    fr[2][0] <= sz[FRAC_BITS-1:0];
    for (int c = 0; c < 3; c++) begin
      for (int s = 1; s < 4; s++) fr[c][s] <= fr[c][s-1];
    end
  end

  // point plus offset, floor split comes from the two's complement bits
  assign sx = SUM_W'(px0) + SUM_W'(x_offset);
  assign sy = SUM_W'(py0) + SUM_W'(y_offset);
  assign sz = SUM_W'(pz0) + SUM_W'(z_offset);

  ign3_hash u_hash (
    .clk(clk), .rst(rst), .ld1(ld1),
    .cell_x(cx1), .cell_y(cy1), .cell_z(cz1), .hash(hash)
  );

  ign3_fade u_fade_x (.clk(clk), .t(fr[0][0]), .fade(fd_x));
  ign3_fade u_fade_y (.clk(clk), .t(fr[1][0]), .fade(fd_y));
  ign3_fade u_fade_z (.clk(clk), .t(fr[2][0]), .fade(fd_z));

  ign3_blend u_blend (
    .clk(clk), .rst(rst), .ev4(ev[3]), .hash(hash),
    .fr_x(fr[0][3]), .fr_y(fr[1][3]), .fr_z(fr[2][3]),
    .fd_x(fd_x), .fd_y(fd_y), .fd_z(fd_z),
    .noise_value(noise_value), .noise_valid(noise_valid)
  );

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    noise_valid |-> $past(start && !busy && command == CMD_EVAL, LAT))
    else $error("result beat without a matching evaluate beat");

  a_eval_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_EVAL) |-> ##LAT noise_valid)
    else $error("evaluate beat lost its result");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_LOAD) |-> ##LAT !noise_valid)
    else $error("load beat produced a result");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks improved_gradient_noise_3d_top against a behavioral noise predictor.
// The permutation table is loaded in full first. Then come directed points,
// and random evaluations mixed with table reloads under several offset
// settings, with random gaps between commands.
// ----------------------------------------------------------------------------
module testbench;
  import ign3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int WATCHDOG  = 3000;
  localparam int OUT_HI    = 131071;
  localparam int OUT_LO    = -131072;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic command = CMD_EVAL;
  logic signed [PT_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [IDX_W-1:0] table_index = '0, table_value = '0;
  logic signed [OUT_W-1:0] noise_value;
  logic noise_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFF_W-1:0] cfg_data = '0;

  logic [7:0] perm_copy [TABLE_SIZE];
  logic [OFF_W-1:0] offset_copy [3];
  logic signed [OUT_W-1:0] pending_noise [$];
  int errors = 0;
  int idle_cycles = 0;

  improved_gradient_noise_3d_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint fade_of(longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    q = 10 * ONE - ((t * (15 * ONE - 6 * t)) >>> FRAC_BITS);
    return (t3 * q) >>> FRAC_BITS;
  endfunction

  function automatic longint mix(longint w, longint a, longint b);
    return a + (((b - a) * w) >>> FRAC_BITS);
  endfunction

  function automatic longint corner_grad(int h, longint x, longint y, longint z);
    int k;
    longint u, v;
    k = h & 15;
    u = (k < 8) ? x : y;
    v = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
    if (h & 1) u = -u;
    if (h & 2) v = -v;
    return u + v;
  endfunction

  function automatic int perm(int i);
    return perm_copy[i & (TABLE_SIZE - 1)];
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(logic signed [PT_W-1:0] px,
      logic signed [PT_W-1:0] py, logic signed [PT_W-1:0] pz);
    longint s [3];
    int c [3];
    longint f [3];
    longint x, y, z, x1, y1, z1, fx, fy, fz, l1, l2, l3, l4, m1, m2, v;
    int a, b, aa, ab, ba, bb;
    s[0] = longint'(px) + offset_copy[0];
    s[1] = longint'(py) + offset_copy[1];
    s[2] = longint'(pz) + offset_copy[2];
    for (int i = 0; i < 3; i++) begin
      c[i] = int'((s[i] >>> FRAC_BITS) & (TABLE_SIZE - 1));
      f[i] = s[i] & (ONE - 1);
    end
    x = f[0]; y = f[1]; z = f[2];
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    fx = fade_of(x); fy = fade_of(y); fz = fade_of(z);
    a = perm(c[0]) + c[1];
    aa = perm(a) + c[2];
    ab = perm(a + 1) + c[2];
    b = perm(c[0] + 1) + c[1];
    ba = perm(b) + c[2];
    bb = perm(b + 1) + c[2];
    l1 = mix(fx, corner_grad(perm(aa), x, y, z), corner_grad(perm(ba), x1, y, z));
    l2 = mix(fx, corner_grad(perm(ab), x, y1, z), corner_grad(perm(bb), x1, y1, z));
    l3 = mix(fx, corner_grad(perm(aa + 1), x, y, z1),
             corner_grad(perm(ba + 1), x1, y, z1));
    l4 = mix(fx, corner_grad(perm(ab + 1), x, y1, z1),
             corner_grad(perm(bb + 1), x1, y1, z1));
    m1 = mix(fy, l1, l2);
    m2 = mix(fy, l3, l4);
    v = mix(fz, m1, m2);
    v = v >>> (FRAC_BITS - 16);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // one command beat, start left high for a back-to-back follower
  task automatic send(logic cmd, logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
      logic signed [PT_W-1:0] pz, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val);
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    point_x = px; point_y = py; point_z = pz;
    table_index = idx; table_value = val;
    do @(posedge clk); while (busy);
    if (cmd == CMD_LOAD) perm_copy[idx] = val;
    else pending_noise.push_back(noise_at(px, py, pz));
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) pause(0);
    else if (r < 92) pause($urandom_range(3, 1));
    else pause($urandom_range(40, 10));
  endtask

  task automatic drain();
    pause(1);
    wait (pending_noise.size() == 0);
    pause(LAT + 4);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx != REG_UNUSED) offset_copy[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_offsets(logic [OFF_W-1:0] ox, logic [OFF_W-1:0] oy,
      logic [OFF_W-1:0] oz);
    drain();
    write_reg(REG_X_OFFSET, ox);
    write_reg(REG_Y_OFFSET, oy);
    write_reg(REG_Z_OFFSET, oz);
  endtask

  task automatic test_table_load();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      send(CMD_LOAD, $urandom, $urandom, $urandom, i[IDX_W-1:0], IDX_W'($urandom));
      if ($urandom_range(3) == 0) random_gap();
    end
  endtask

  task automatic test_directed_points();
    logic signed [PT_W-1:0] corner [6];
    corner = '{32'sh0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sh0000ffff, 32'sh00010000};
    for (int i = 0; i < 6; i++) send(CMD_EVAL, corner[i], corner[i], corner[i], '0, '0);
    send(CMD_EVAL, corner[1], corner[2], corner[3], '0, '0);
    send(CMD_EVAL, corner[2], corner[4], corner[1], '0, '0);
    // lattice wrap: cell 255 needs entry 0 for the +1 corner
    send(CMD_EVAL, 32'sh00ff8000, 32'sh00ff8000, 32'sh00ff8000, '0, '0);
    send(CMD_LOAD, '0, '0, '0, 8'hff, 8'hff);
    send(CMD_LOAD, '0, '0, '0, 8'h00, 8'h00);
    send(CMD_EVAL, 32'sh00ff4000, 32'sh0000c000, 32'sh00ffffff, '0, '0);
    pause(2);
  endtask

  task automatic random_items(int n);
    logic signed [PT_W-1:0] p [3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++)
        p[k] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(65535 * 8)) - 32'sd262140;
      if ($urandom_range(99) < 15)
        send(CMD_LOAD, p[0], p[1], p[2], IDX_W'($urandom), IDX_W'($urandom));
      else
        send(CMD_EVAL, p[0], p[1], p[2], IDX_W'($urandom), IDX_W'($urandom));
      random_gap();
    end
  endtask

  task automatic test_offset_settings();
    set_offsets('0, '0, '0);
    random_items(300);
    set_offsets('1, '1, '1);
    test_directed_points();
    random_items(300);
    set_offsets(OFF_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
    random_items(300);
    drain();
    write_reg(REG_UNUSED, OFF_W'($urandom));
    random_items(200);
    set_offsets(24'h008000, 24'hff0000, 24'h000001);
    random_items(300);
  endtask

  task automatic test_random_stream();
    set_offsets(OFF_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
    random_items(270);
  endtask

  always @(posedge clk) begin
    if (!rst && noise_valid) begin
      if (pending_noise.size() == 0) begin
        report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
      end else begin
        if (noise_value !== pending_noise[0])
          report_mismatch($sformatf("noise_value %0d, expected %0d",
                                    noise_value, pending_noise[0]));
        void'(pending_noise.pop_front());
      end
    end
    if (rst || (start && !busy) || noise_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    offset_copy = '{default: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_load();
    test_directed_points();
    test_offset_settings();
    test_random_stream();
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
